@@ rtl/tcm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_pkg
// Types and constants shared by the trapezoidal circular motion block.
// ----------------------------------------------------------------------------
package tcm_pkg;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_REST   = 2'd3
    } tcm_phase_t;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_END    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ANGLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_ANGLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd7;

    localparam logic [31:0] STOP_SPEED   = 32'd26844;
    localparam logic [31:0] INV_TWO_PI   = 32'd683565276;
    localparam logic [31:0] CORDIC_GAIN  = 32'd2608131496;
    localparam int          CORDIC_STEPS = 30;
    localparam logic signed [25:0] POS_MAX = 26'sd33554431;
    localparam logic signed [25:0] POS_MIN = -26'sd33554432;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef struct packed {
        logic [31:0] accel_rate;
        logic [31:0] decel_rate;
        logic [31:0] accel_end;
        logic [31:0] cruise_end;
        logic [31:0] decel_end;
        logic [31:0] accel_angle;
        logic [31:0] cruise_angle;
        logic [31:0] cruise_speed;
    } tcm_cfg_t;

    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] angle;
        tcm_phase_t  phase;
        logic        rest;
    } tcm_side_t;

    typedef struct packed {
        logic signed [25:0] pos_x;
        logic signed [25:0] pos_z;
        tcm_side_t          side;
    } tcm_result_t;

endpackage
`default_nettype wire

@@ rtl/trapezoidal_circular_motion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoidal_circular_motion
// Trapezoidal angular motion profile with the point on a circle.
// ----------------------------------------------------------------------------
// Send elapsed time words (Q12.20 seconds) on the s_ channel. Each word gives
// one result word on the m_ channel: x and z on the circle, angular speed and
// angle in m_tdata, phase and rest flag in m_tuser.
// From input accept to m_tvalid a word passes six stages of profile
// arithmetic, one turn multiply, one CORDIC setup stage, thirty CORDIC
// rotation stages, quadrant fold, rounding, and the output buffer.
// Throughput is one word per cycle while the buffer has room; stages move together.
// Write profile registers through cfg_we / cfg_index / cfg_wdata between runs.
// Synchronous reset empties the pipeline and loads the default profile.
// When the receiver drops m_tready, the two-word output buffer fills, then
// the pipeline and s_tready hold until a word drains; nothing is dropped.
// ----------------------------------------------------------------------------
module trapezoidal_circular_motion #(
    parameter int RADIUS = 50
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,  // elapsed_time
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // position_x, position_z, angular_speed, rotation_angle, zero pad
    output logic [119:0]                          m_tdata,
    output logic [2:0]                            m_tuser,  // motion_phase, at_rest
    input  wire logic                             cfg_we,
    input  wire logic [tcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_wdata
);

    tcm_pkg::tcm_cfg_t    cfg_reg;
    logic                 ce;
    logic                 prof_valid, cord_valid;
    tcm_pkg::tcm_side_t   prof_side;
    tcm_pkg::tcm_result_t cord_result, out_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_rate   <= 32'd10737418;
            cfg_reg.decel_rate   <= 32'd8053064;
            cfg_reg.accel_end    <= 32'd26283921;
            cfg_reg.cruise_end   <= 32'd45996835;
            cfg_reg.decel_end    <= 32'd81042028;
            cfg_reg.accel_angle  <= 32'd210828714;
            cfg_reg.cruise_angle <= 32'd316243082;
            cfg_reg.cruise_speed <= 32'd269147078;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcm_pkg::REG_ACCEL_RATE:   cfg_reg.accel_rate   <= cfg_wdata;
                tcm_pkg::REG_DECEL_RATE:   cfg_reg.decel_rate   <= cfg_wdata;
                tcm_pkg::REG_ACCEL_END:    cfg_reg.accel_end    <= cfg_wdata;
                tcm_pkg::REG_CRUISE_END:   cfg_reg.cruise_end   <= cfg_wdata;
                tcm_pkg::REG_DECEL_END:    cfg_reg.decel_end    <= cfg_wdata;
                tcm_pkg::REG_ACCEL_ANGLE:  cfg_reg.accel_angle  <= cfg_wdata;
                tcm_pkg::REG_CRUISE_ANGLE: cfg_reg.cruise_angle <= cfg_wdata;
                tcm_pkg::REG_CRUISE_SPEED: cfg_reg.cruise_speed <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = ce;

    tcm_profile u_profile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .t         (s_tdata),
        .cfg       (cfg_reg),
        .out_valid (prof_valid),
        .out_side  (prof_side)
    );

    tcm_cordic #(
        .RADIUS (RADIUS)
    ) u_cordic (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (prof_valid),
        .in_side    (prof_side),
        .out_valid  (cord_valid),
        .out_result (cord_result)
    );

    tcm_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cord_valid),
        .in_data   (cord_result),
        .room      (ce),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {4'b0000, out_word.side.angle, out_word.side.speed,
                      out_word.pos_z, out_word.pos_x};
    assign m_tuser = {out_word.side.rest, out_word.side.phase};

endmodule
`default_nettype wire

@@ rtl/tcm_profile.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_profile
// Six-stage evaluator of phase, angle and speed of the trapezoidal profile.
// ----------------------------------------------------------------------------
module tcm_profile (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               ce,
    input  wire logic               in_valid,
    input  wire logic [31:0]        t,
    input  wire tcm_pkg::tcm_cfg_t  cfg,
    output logic                    out_valid,
    output tcm_pkg::tcm_side_t      out_side
);

    logic [5:0] v_reg;

    // stage 1
    tcm_pkg::tcm_phase_t ph1_reg, ph1_next;
    logic [31:0] x1_reg, x1_next;
    logic        ge1_reg;
    // stage 2
    tcm_pkg::tcm_phase_t ph2_reg;
    logic [63:0] sq2_reg, l1_2_reg, l2_2_reg;
    logic        ge2_reg;
    logic [31:0] rate_a;
    // stage 3
    tcm_pkg::tcm_phase_t ph3_reg;
    logic [63:0] phi3_reg, plo3_reg;
    logic [43:0] spd3_reg, drop3_reg;
    logic [39:0] lin3_reg;
    logic        ge3_reg;
    logic [31:0] rate_b;
    // stage 4
    tcm_pkg::tcm_phase_t ph4_reg;
    logic [63:0] mid4_reg;
    logic [40:0] tot4_reg, tot4_next;
    logic [31:0] spd4_reg, spd4_next;
    logic        ge4_reg;
    // stage 5
    tcm_pkg::tcm_phase_t ph5_reg;
    logic [51:0] q5_reg;
    logic [40:0] tot5_reg;
    logic [31:0] spd5_reg;
    logic        rest5_reg;
    // stage 6
    logic [31:0] ang6_next;
    logic [51:0] diff;
    tcm_pkg::tcm_side_t side6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_comb begin
        if (t <= cfg.accel_end) begin
            ph1_next = tcm_pkg::PH_ACCEL;
            x1_next  = t;
        end else if (t <= cfg.cruise_end) begin
            ph1_next = tcm_pkg::PH_CRUISE;
            x1_next  = t - cfg.accel_end;
        end else if (t <= cfg.decel_end) begin
            ph1_next = tcm_pkg::PH_DECEL;
            x1_next  = t - cfg.cruise_end;
        end else begin
            ph1_next = tcm_pkg::PH_REST;
            x1_next  = (cfg.decel_end > cfg.cruise_end) ? cfg.decel_end - cfg.cruise_end
                                                        : 32'd0;
        end
    end

    assign rate_a = (ph1_reg == tcm_pkg::PH_ACCEL) ? cfg.accel_rate : cfg.cruise_speed;
    assign rate_b = (ph2_reg == tcm_pkg::PH_ACCEL) ? cfg.accel_rate : cfg.decel_rate;

    always_comb begin
        if (ph3_reg == tcm_pkg::PH_CRUISE) begin
            tot4_next = 41'(cfg.accel_angle) + 41'(lin3_reg);
        end else begin
            tot4_next = 41'(cfg.accel_angle) + 41'(cfg.cruise_angle) + 41'(lin3_reg);
        end
        case (ph3_reg)
            tcm_pkg::PH_ACCEL:  spd4_next = (spd3_reg > 44'hFFFFFFFF) ? 32'hFFFFFFFF
                                                                      : spd3_reg[31:0];
            tcm_pkg::PH_CRUISE: spd4_next = cfg.cruise_speed;
            tcm_pkg::PH_DECEL:  spd4_next = (drop3_reg >= 44'(cfg.cruise_speed)) ? 32'd0
                                            : cfg.cruise_speed - drop3_reg[31:0];
            default:            spd4_next = 32'd0;
        endcase
    end

    always_comb begin
        diff = 52'(tot5_reg) - q5_reg;
        case (ph5_reg)
            tcm_pkg::PH_ACCEL:  ang6_next = (q5_reg > 52'hFFFFFFFF) ? 32'hFFFFFFFF
                                                                    : q5_reg[31:0];
            tcm_pkg::PH_CRUISE: ang6_next = (tot5_reg > 41'hFFFFFFFF) ? 32'hFFFFFFFF
                                                                      : tot5_reg[31:0];
            default: begin
                if (q5_reg >= 52'(tot5_reg)) begin
                    ang6_next = 32'd0;
                end else begin
                    ang6_next = (diff > 52'hFFFFFFFF) ? 32'hFFFFFFFF : diff[31:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ph1_reg   <= ph1_next;
            x1_reg    <= x1_next;
            ge1_reg   <= (t >= cfg.decel_end);

            ph2_reg   <= ph1_reg;
            ge2_reg   <= ge1_reg;
            sq2_reg   <= 64'(x1_reg) * 64'(x1_reg);
            l1_2_reg  <= 64'(rate_a) * 64'(x1_reg);
            l2_2_reg  <= 64'(cfg.decel_rate) * 64'(x1_reg);

            ph3_reg   <= ph2_reg;
            ge3_reg   <= ge2_reg;
            phi3_reg  <= 64'(sq2_reg[63:32]) * 64'(rate_b);
            plo3_reg  <= 64'(sq2_reg[31:0]) * 64'(rate_b);
            spd3_reg  <= 44'((l1_2_reg + 64'd524288) >> 20);
            lin3_reg  <= 40'((l1_2_reg + 64'd8388608) >> 24);
            drop3_reg <= 44'((l2_2_reg + 64'd524288) >> 20);

            ph4_reg   <= ph3_reg;
            ge4_reg   <= ge3_reg;
            mid4_reg  <= phi3_reg + {32'd0, plo3_reg[63:32]};
            tot4_reg  <= tot4_next;
            spd4_reg  <= spd4_next;

            ph5_reg   <= ph4_reg;
            q5_reg    <= 52'((65'(mid4_reg) + 65'd4096) >> 13);
            tot5_reg  <= tot4_reg;
            spd5_reg  <= spd4_reg;
            rest5_reg <= ge4_reg && (spd4_reg <= tcm_pkg::STOP_SPEED);

            side6_reg.speed <= spd5_reg;
            side6_reg.angle <= ang6_next;
            side6_reg.phase <= ph5_reg;
            side6_reg.rest  <= rest5_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign out_side  = side6_reg;

endmodule
`default_nettype wire

@@ rtl/tcm_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_cordic
// Angle to turn fraction, 30 pipelined CORDIC rotations, quadrant fold and
// rounding of the circle point to Q11.14.
// ----------------------------------------------------------------------------
module tcm_cordic #(
    parameter int RADIUS = 50
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                ce,
    input  wire logic                in_valid,
    input  wire tcm_pkg::tcm_side_t  in_side,
    output logic                     out_valid,
    output tcm_pkg::tcm_result_t     out_result
);

    localparam int N = tcm_pkg::CORDIC_STEPS;
    localparam logic signed [47:0] X_INIT =
        48'((64'(RADIUS) * 64'(tcm_pkg::CORDIC_GAIN) + 64'd2) >> 2);

    function automatic logic signed [25:0] pos_round(input logic signed [47:0] v);
        logic signed [48:0] w;
        w = (49'(v) + 49'sd32768) >>> 16;
        if (w > 49'(tcm_pkg::POS_MAX)) begin
            pos_round = tcm_pkg::POS_MAX;
        end else if (w < 49'(tcm_pkg::POS_MIN)) begin
            pos_round = tcm_pkg::POS_MIN;
        end else begin
            pos_round = w[25:0];
        end
    endfunction

    logic        vt_reg, vm_reg, vo_reg;
    logic [31:0] turn_reg;
    logic [63:0] turn_prod;
    tcm_pkg::tcm_side_t sidet_reg, sidem_reg, sideo_reg;

    logic signed [47:0] x_reg [0:N];
    logic signed [47:0] y_reg [0:N];
    logic signed [31:0] z_reg [0:N];
    logic [1:0]         q_reg [0:N];
    logic               v_reg [0:N];
    tcm_pkg::tcm_side_t s_reg [0:N];

    logic signed [47:0] c_reg, sn_reg, c_next, sn_next;
    logic signed [25:0] px_reg, pz_reg;

    assign turn_prod = 64'(in_side.angle) * 64'(tcm_pkg::INV_TWO_PI);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vt_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            vt_reg   <= in_valid;
            v_reg[0] <= vt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            turn_reg  <= turn_prod[55:24];
            sidet_reg <= in_side;
            x_reg[0]  <= X_INIT;
            y_reg[0]  <= '0;
            z_reg[0]  <= {2'b00, turn_reg[29:0]};
            q_reg[0]  <= turn_reg[31:30];
            s_reg[0]  <= sidet_reg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (ce) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - signed'(tcm_pkg::ATAN_TURNS[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + signed'(tcm_pkg::ATAN_TURNS[i]);
                end
                q_reg[i+1] <= q_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    always_comb begin
        case (q_reg[N])
            2'd0: begin
                c_next  = x_reg[N];
                sn_next = y_reg[N];
            end
            2'd1: begin
                c_next  = -y_reg[N];
                sn_next = x_reg[N];
            end
            2'd2: begin
                c_next  = -x_reg[N];
                sn_next = -y_reg[N];
            end
            default: begin
                c_next  = y_reg[N];
                sn_next = -x_reg[N];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (ce) begin
            vm_reg <= v_reg[N];
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_reg     <= c_next;
            sn_reg    <= sn_next;
            sidem_reg <= s_reg[N];
            px_reg    <= pos_round(c_reg);
            pz_reg    <= pos_round(sn_reg);
            sideo_reg <= sidem_reg;
        end
    end

    assign out_valid        = vo_reg;
    assign out_result.pos_x = px_reg;
    assign out_result.pos_z = pz_reg;
    assign out_result.side  = sideo_reg;

endmodule
`default_nettype wire

@@ rtl/tcm_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_outbuf
// Two-word output buffer; frees the pipeline from the receiver's tready.
// ----------------------------------------------------------------------------
module tcm_outbuf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire tcm_pkg::tcm_result_t  in_data,
    output logic                       room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tcm_pkg::tcm_result_t       out_data
);

    tcm_pkg::tcm_result_t mem_reg [0:1];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign room      = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && room;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tcm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_checker
// Port-level checks of the trapezoidal circular motion block.
// ----------------------------------------------------------------------------
module tcm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [119:0]                  m_tdata,
    input wire logic [2:0]                    m_tuser
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("word shown right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled word changed");

    a_rest_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == tcm_pkg::PH_REST |-> m_tuser[2] && m_tdata[83:52] == 32'd0)
        else $error("rest phase without zero speed and rest flag");

    a_rest_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[83:52] <= tcm_pkg::STOP_SPEED)
        else $error("rest flag above stop speed");

endmodule

bind trapezoidal_circular_motion tcm_checker u_tcm_checker (.*);
`default_nettype wire
